>>> hdl/frustum_box_cull_unit_assert.svh
// Assertion macros shared by the culling unit
`ifndef FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fbc_pkg.sv
package fbc_pkg;

    localparam int COORD_W    = 16;
    localparam int MAT_W      = 16;
    localparam int FRAC_BITS  = 12;
    localparam int NUM_COLS   = 4;
    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int NUM_CELLS  = NUM_PLANES * NUM_AXES;
    localparam int CFG_W      = NUM_COLS * MAT_W;
    localparam int COEF_W     = MAT_W + 1;
    localparam int PROD_W     = COEF_W + COORD_W;
    // three products plus an offset: two guard bits
    localparam int ACC_W      = PROD_W + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [MAT_W-1:0]   mat_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [CFG_W-1:0]          cfg_data_t;
    typedef cfg_data_t [NUM_COLS-1:0]  col_array_t;
    typedef coef_t [NUM_COLS-1:0]      plane_coef_t;
    typedef plane_coef_t [NUM_PLANES-1:0] plane_coefs_t;

    typedef enum logic [1:0] {
        CFG_COLUMN_0,
        CFG_COLUMN_1,
        CFG_COLUMN_2,
        CFG_COLUMN_3
    } cfg_index_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // data carried from cell to cell
    typedef struct packed {
        coord_t [NUM_AXES-1:0] lo;
        coord_t [NUM_AXES-1:0] hi;
        acc_t                  acc;
        logic                  vis;
    } stage_t;

    // identity matrix: column c holds 1.0 in row c
    function automatic cfg_data_t col_reset(input int c);
        return cfg_data_t'(1) << (MAT_W * c + FRAC_BITS);
    endfunction

endpackage

>>> hdl/fbc_if.sv
interface fbc_box_if;
    import fbc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fbc_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink   (input valid, visible, output ready);
endinterface

>>> hdl/frustum_box_cull_unit.sv
// Frustum culling of axis-aligned boxes. Four 64-bit column registers hold a
// column-major view-projection matrix (Q3.12 per element, row r in bits
// 16r+15..16r); they reset to identity and should be written only while the
// unit is empty. Six clip planes (row 3 plus/minus rows 0, 1, 2) are derived
// from the matrix. Each box item is tested against all planes via its
// p-vertex and yields one result item: visible = 0 when some plane puts the
// whole box behind it, a distance of exactly zero counting as inside. A point
// is tested by sending min equal to max. Throughput is one item per clock
// while result.ready is high. Items pass an 18-cell chain (six planes times
// three axes), each cell doing one 17x16 multiply and one accumulate. Every
// cell holds its own item, so bubbles close up under back-pressure and input
// keeps flowing until the whole chain is full. No clearing pass after reset.
module frustum_box_cull_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  fbc_pkg::cfg_index_t   cfg_index,
    input  fbc_pkg::cfg_data_t    cfg_data,
    fbc_box_if.sink               box,
    fbc_result_if.source          result
);
    import fbc_pkg::*;

    // matrix columns as written
    col_array_t   column_reg;
    // plane coefficients, static between config writes
    plane_coefs_t coefs;

    // chain links: index 0 is the input, index NUM_CELLS the output
    logic   valid_chain [NUM_CELLS+1];
    logic   ready_chain [NUM_CELLS+1];
    stage_t data_chain  [NUM_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                column_reg[c] <= col_reset(c);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLUMN_0: column_reg[0] <= cfg_data;
                CFG_COLUMN_1: column_reg[1] <= cfg_data;
                CFG_COLUMN_2: column_reg[2] <= cfg_data;
                CFG_COLUMN_3: column_reg[3] <= cfg_data;
            endcase
        end
    end

    fbc_plane_gen u_plane_gen (
        .columns (column_reg),
        .coefs   (coefs)
    );

    // input item enters with its verdict still visible
    always_comb
    begin
        data_chain[0]       = '0;
        data_chain[0].lo[0] = box.min_x;
        data_chain[0].lo[1] = box.min_y;
        data_chain[0].lo[2] = box.min_z;
        data_chain[0].hi[0] = box.max_x;
        data_chain[0].hi[1] = box.max_y;
        data_chain[0].hi[2] = box.max_z;
        data_chain[0].vis   = 1'b1;
    end

    assign valid_chain[0] = box.valid;
    assign box.ready      = ready_chain[0];

    // cell j works on plane j/3, axis j%3; the first axis seeds the offset
    // term and the last one takes the sign of the finished distance
    for (genvar j = 0; j < NUM_CELLS; j++)
    begin : g_cell
        localparam int PLANE = j / NUM_AXES;
        localparam int AXIS  = j % NUM_AXES;

        fbc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef      (coefs[PLANE][AXIS]),
            .seed      (coefs[PLANE][NUM_COLS-1]),
            .axis      (axis_t'(AXIS)),
            .first     (AXIS == 0),
            .last      (AXIS == NUM_AXES - 1),
            .in_valid  (valid_chain[j]),
            .in_ready  (ready_chain[j]),
            .in_data   (data_chain[j]),
            .out_valid (valid_chain[j+1]),
            .out_ready (ready_chain[j+1]),
            .out_data  (data_chain[j+1])
        );
    end

    assign ready_chain[NUM_CELLS] = result.ready;
    assign result.valid           = valid_chain[NUM_CELLS];
    assign result.visible         = data_chain[NUM_CELLS].vis;

endmodule

>>> hdl/fbc_plane_gen.sv
module fbc_plane_gen (
    input  fbc_pkg::col_array_t   columns,
    output fbc_pkg::plane_coefs_t coefs
);
    import fbc_pkg::*;

    // plane p: row 3 plus row p/2 for even p, minus it for odd p
    always_comb
    begin
        mat_t a;
        mat_t b;
        int   r;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            r = p >> 1;
            for (int c = 0; c < NUM_COLS; c++)
            begin
                a = mat_t'(columns[c][MAT_W*3 +: MAT_W]);
                b = mat_t'(columns[c][MAT_W*r +: MAT_W]);
                if (p[0])
                begin
                    coefs[p][c] = coef_t'(a) - coef_t'(b);
                end
                else
                begin
                    coefs[p][c] = coef_t'(a) + coef_t'(b);
                end
            end
        end
    end

endmodule

>>> hdl/fbc_cell.sv
`include "frustum_box_cull_unit_assert.svh"

module fbc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  fbc_pkg::coef_t  coef,
    input  fbc_pkg::coef_t  seed,
    input  fbc_pkg::axis_t  axis,
    input  logic            first,
    input  logic            last,
    input  logic            in_valid,
    output logic            in_ready,
    input  fbc_pkg::stage_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output fbc_pkg::stage_t out_data
);
    import fbc_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    coord_t sel;
    prod_t  prod;
    acc_t   base;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        unique case (axis)
            AXIS_X:  sel = coef[COEF_W-1] ? in_data.lo[0] : in_data.hi[0];
            AXIS_Y:  sel = coef[COEF_W-1] ? in_data.lo[1] : in_data.hi[1];
            default: sel = coef[COEF_W-1] ? in_data.lo[2] : in_data.hi[2];
        endcase
        prod = prod_t'(coef) * prod_t'(sel);
        base = first ? acc_t'(seed) : in_data.acc;
        data_next     = in_data;
        data_next.acc = base + acc_t'(prod);
        // plane done: a negative distance culls the box
        data_next.vis = in_data.vis && !(last && data_next.acc[ACC_W-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    `FBC_ASSERT_NEXT(a_hold_stalled, clk, rst_n, valid_reg && !out_ready, valid_reg && $stable(data_reg), "stalled item changed")
    `FBC_ASSERT_NEXT(a_cull_sticks, clk, rst_n, in_valid && in_ready && !in_data.vis, !data_reg.vis, "culled item revived")
    `FBC_ASSERT_NEXT(a_vis_only_last, clk, rst_n, in_valid && in_ready && !last, data_reg.vis == $past(in_data.vis), "verdict changed mid plane")
    `FBC_ASSERT_NEXT(a_drain, clk, rst_n, valid_reg && out_ready && !in_valid, !valid_reg, "item repeated")

endmodule
